// File: sv/morse_pkg.sv
// Shared types, constants and the Morse code table for the Morse keyer.
// Used by morse_ctrl, morse_dp and morse_keyer; depends on nothing.
`default_nettype none

package morse_pkg;

    localparam int CHAR_W  = 8;
    localparam int UNITS_W = 3;
    localparam int ELEM_W  = 3;
    localparam int PAT_W   = 5;

    localparam logic [UNITS_W-1:0] DOT_UNITS      = 3'd1;
    localparam logic [UNITS_W-1:0] DASH_UNITS     = 3'd3;
    localparam logic [UNITS_W-1:0] GAP_UNITS      = 3'd1;
    localparam logic [UNITS_W-1:0] CHAR_END_UNITS = 3'd3;
    localparam logic [UNITS_W-1:0] WORD_UNITS     = 3'd7;

    localparam logic [CHAR_W-1:0] CHAR_HT    = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIT,
        ST_GAP,
        ST_END,
        ST_WORD
    } state_t;

    typedef enum logic [1:0] {
        SEG_LIT,
        SEG_GAP,
        SEG_END,
        SEG_WORD
    } seg_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic advance;
        seg_t seg;
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic white;
        logic in_run;
        logic mapped;
        logic last_elem;
    } status_t;

    // element i of the character sits at pattern bit i, 1 = dash
    typedef struct packed {
        logic [ELEM_W-1:0] len;
        logic [PAT_W-1:0]  pat;
    } code_t;

    function automatic logic is_white(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_HT && c <= CHAR_CR) || c == CHAR_SPACE;
    endfunction

    function automatic code_t morse_lookup(input logic [CHAR_W-1:0] c);
        code_t r;
        unique case (c)
            "A": r = '{3'd2, 5'b00010};
            "B": r = '{3'd4, 5'b00001};
            "C": r = '{3'd4, 5'b00101};
            "D": r = '{3'd3, 5'b00001};
            "E": r = '{3'd1, 5'b00000};
            "F": r = '{3'd4, 5'b00100};
            "G": r = '{3'd3, 5'b00011};
            "H": r = '{3'd4, 5'b00000};
            "I": r = '{3'd2, 5'b00000};
            "J": r = '{3'd4, 5'b01110};
            "K": r = '{3'd3, 5'b00101};
            "L": r = '{3'd4, 5'b00010};
            "M": r = '{3'd2, 5'b00011};
            "N": r = '{3'd2, 5'b00001};
            "O": r = '{3'd3, 5'b00111};
            "P": r = '{3'd4, 5'b00110};
            "Q": r = '{3'd4, 5'b01011};
            "R": r = '{3'd3, 5'b00010};
            "S": r = '{3'd3, 5'b00000};
            "T": r = '{3'd1, 5'b00001};
            "U": r = '{3'd3, 5'b00100};
            "V": r = '{3'd4, 5'b01000};
            "W": r = '{3'd3, 5'b00110};
            "X": r = '{3'd4, 5'b01001};
            "Y": r = '{3'd4, 5'b01101};
            "Z": r = '{3'd4, 5'b00011};
            "0": r = '{3'd5, 5'b11111};
            "1": r = '{3'd5, 5'b11110};
            "2": r = '{3'd5, 5'b11100};
            "3": r = '{3'd5, 5'b11000};
            "4": r = '{3'd5, 5'b10000};
            "5": r = '{3'd5, 5'b00000};
            "6": r = '{3'd5, 5'b00001};
            "7": r = '{3'd5, 5'b00011};
            "8": r = '{3'd5, 5'b00111};
            "9": r = '{3'd5, 5'b01111};
            default: r = '{3'd0, 5'b00000};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/morse_keyer.sv
// Morse keyer top level: one ASCII character in, timed LED segments out.
// Slave channel s_* takes characters; master channel m_* gives segments,
// one word per segment: LED lit or dark and a length in Morse time units.
// A-Z and 0-9 give their dots (1 unit lit) and dashes (3 units lit) with
// 1-unit dark gaps, then a 3-unit dark close. Other characters give the
// 3-unit close only. The first whitespace (HT..CR, space) of a run gives one
// 7-unit dark word; further whitespace in the run gives nothing.
// m_tlast marks the final segment of a character.
// The first segment is presented in the cycle after the character is taken.
// A character gives up to ten segments (a five-element character); a repeated
// whitespace is taken and gives none. The segment sequencer handles one
// character at a time, so s_tready is high only between characters.
// Each segment holds on m_tdata while m_tready is low; nothing is dropped.
// Reset (aresetn low at a clock edge) returns to idle and clears the
// whitespace-run flag.
`default_nettype none

module morse_keyer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] character
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [0] led_lit, [3:1] units, [7:4] zero
    output logic            m_tlast    // last_segment
);

    morse_pkg::ctrl_t                  ctrl;
    morse_pkg::status_t                status;
    logic                              led_lit;
    logic [morse_pkg::UNITS_W-1:0]     units;

    morse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    morse_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .character    (s_tdata),
        .ctrl         (ctrl),
        .status       (status),
        .led_lit      (led_lit),
        .units        (units),
        .last_segment (m_tlast)
    );

    assign m_tdata = {4'b0000, units, led_lit};

endmodule

`default_nettype wire

// File: sv/morse_ctrl.sv
// Morse keyer controller: sequences the segments of one character.
// Depends on morse_pkg; drives morse_dp through morse_pkg::ctrl_t.
`default_nettype none

module morse_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire morse_pkg::status_t status,
    output morse_pkg::ctrl_t       ctrl
);

    morse_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= morse_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        logic s_fire;
        logic m_fire;
        s_fire       = 1'b0;
        m_fire       = 1'b0;
        state_next   = state_reg;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        ctrl.load    = 1'b0;
        ctrl.advance = 1'b0;
        ctrl.seg     = morse_pkg::SEG_END;
        m_fire       = m_tready;
        unique case (state_reg)
            morse_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                s_fire    = s_tvalid;
                ctrl.load = s_fire;
                if (s_fire) begin
                    priority if (status.white && status.in_run) begin
                        state_next = morse_pkg::ST_IDLE;
                    end else if (status.white) begin
                        state_next = morse_pkg::ST_WORD;
                    end else if (status.mapped) begin
                        state_next = morse_pkg::ST_LIT;
                    end else begin
                        state_next = morse_pkg::ST_END;
                    end
                end
            end
            morse_pkg::ST_LIT: begin
                m_tvalid     = 1'b1;
                ctrl.seg     = morse_pkg::SEG_LIT;
                ctrl.advance = m_fire;
                if (m_fire) begin
                    state_next = status.last_elem ? morse_pkg::ST_END : morse_pkg::ST_GAP;
                end
            end
            morse_pkg::ST_GAP: begin
                m_tvalid = 1'b1;
                ctrl.seg = morse_pkg::SEG_GAP;
                if (m_fire) begin
                    state_next = morse_pkg::ST_LIT;
                end
            end
            morse_pkg::ST_END: begin
                m_tvalid = 1'b1;
                ctrl.seg = morse_pkg::SEG_END;
                if (m_fire) begin
                    state_next = morse_pkg::ST_IDLE;
                end
            end
            morse_pkg::ST_WORD: begin
                m_tvalid = 1'b1;
                ctrl.seg = morse_pkg::SEG_WORD;
                if (m_fire) begin
                    state_next = morse_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = morse_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/morse_dp.sv
// Morse keyer datapath: code lookup, element pattern shifter, whitespace-run flag
// and segment formatting. Depends on morse_pkg; commanded by morse_ctrl.
`default_nettype none

module morse_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [morse_pkg::CHAR_W-1:0]      character,
    input  wire morse_pkg::ctrl_t                  ctrl,
    output morse_pkg::status_t                     status,
    output logic                                   led_lit,
    output logic [morse_pkg::UNITS_W-1:0]          units,
    output logic                                   last_segment
);

    logic                           run_reg, run_next;
    logic [morse_pkg::PAT_W-1:0]    pat_reg, pat_next;
    logic [morse_pkg::ELEM_W-1:0]   rem_reg, rem_next;
    morse_pkg::code_t               code;
    logic                           white;

    assign white = morse_pkg::is_white(character);
    assign code  = morse_pkg::morse_lookup(character);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge aclk) begin
        pat_reg <= pat_next;
        rem_reg <= rem_next;
    end

    always_comb begin
        run_next = run_reg;
        pat_next = pat_reg;
        rem_next = rem_reg;
        if (ctrl.load) begin
            run_next = white;
            pat_next = code.pat;
            rem_next = code.len;
        end else if (ctrl.advance) begin
            pat_next = pat_reg >> 1;
            rem_next = rem_reg - 3'd1;
        end
    end

    assign status.white     = white;
    assign status.in_run    = run_reg;
    assign status.mapped    = (code.len != '0);
    assign status.last_elem = (rem_reg == 3'd1);

    always_comb begin
        unique case (ctrl.seg)
            morse_pkg::SEG_LIT: begin
                led_lit      = 1'b1;
                units        = pat_reg[0] ? morse_pkg::DASH_UNITS : morse_pkg::DOT_UNITS;
                last_segment = 1'b0;
            end
            morse_pkg::SEG_GAP: begin
                led_lit      = 1'b0;
                units        = morse_pkg::GAP_UNITS;
                last_segment = 1'b0;
            end
            morse_pkg::SEG_END: begin
                led_lit      = 1'b0;
                units        = morse_pkg::CHAR_END_UNITS;
                last_segment = 1'b1;
            end
            default: begin
                led_lit      = 1'b0;
                units        = morse_pkg::WORD_UNITS;
                last_segment = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: tb/sv/morse_seg_checker.sv
// Segment checker for the Morse keyer: watches both stream channels, predicts the
// LED segments of every accepted character and compares them word by word.
// Depends on morse_pkg for the segment lengths; drives only its two counters.
`timescale 1ns / 100ps

module morse_seg_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    output int         errors,
    output int         n_pending
);

    typedef struct packed {
        logic                           lit;
        logic [morse_pkg::UNITS_W-1:0]  units;
        logic                           last;
    } led_seg_t;

    led_seg_t pending_segs[$];
    logic     word_gap_sent;

    initial begin
        errors    = 0;
        n_pending = 0;
    end

    function automatic led_seg_t make_seg(input logic lit,
                                          input logic [morse_pkg::UNITS_W-1:0] units,
                                          input logic last);
        led_seg_t s;
        s.lit   = lit;
        s.units = units;
        s.last  = last;
        return s;
    endfunction

    // dot/dash spelling, first element in the highest nonzero byte
    function automatic logic [39:0] morse_spelling(input logic [7:0] c);
        logic [39:0] p;
        case (c)
            "A": p = ".-";    "B": p = "-...";  "C": p = "-.-.";  "D": p = "-..";
            "E": p = ".";     "F": p = "..-.";  "G": p = "--.";   "H": p = "....";
            "I": p = "..";    "J": p = ".---";  "K": p = "-.-";   "L": p = ".-..";
            "M": p = "--";    "N": p = "-.";    "O": p = "---";   "P": p = ".--.";
            "Q": p = "--.-";  "R": p = ".-.";   "S": p = "...";   "T": p = "-";
            "U": p = "..-";   "V": p = "...-";  "W": p = ".--";   "X": p = "-..-";
            "Y": p = "-.--";  "Z": p = "--..";
            "0": p = "-----"; "1": p = ".----"; "2": p = "..---"; "3": p = "...--";
            "4": p = "....-"; "5": p = "....."; "6": p = "-...."; "7": p = "--...";
            "8": p = "---.."; "9": p = "----.";
            default: p = '0;
        endcase
        return p;
    endfunction

    task automatic queue_segments(input logic [7:0] c);
        logic [39:0] spell;
        logic [7:0]  sym;
        logic        first;
        if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32) begin
            if (!word_gap_sent)
                pending_segs.push_back(make_seg(1'b0, morse_pkg::WORD_UNITS, 1'b1));
            word_gap_sent = 1'b1;
        end else begin
            word_gap_sent = 1'b0;
            spell = morse_spelling(c);
            first = 1'b1;
            for (int i = 4; i >= 0; i--) begin
                sym = spell[i*8 +: 8];
                if (sym != 8'h00) begin
                    if (!first)
                        pending_segs.push_back(make_seg(1'b0, morse_pkg::GAP_UNITS, 1'b0));
                    pending_segs.push_back(make_seg(1'b1,
                        (sym == "-") ? morse_pkg::DASH_UNITS : morse_pkg::DOT_UNITS, 1'b0));
                    first = 1'b0;
                end
            end
            pending_segs.push_back(make_seg(1'b0, morse_pkg::CHAR_END_UNITS, 1'b1));
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $time, what);
        errors = errors + 1;
    endtask

    always @(posedge aclk) begin
        led_seg_t want;
        if (!aresetn) begin
            pending_segs.delete();
            word_gap_sent = 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                queue_segments(s_tdata);
            if (m_tvalid && m_tready) begin
                if (pending_segs.size() == 0) begin
                    report_mismatch($sformatf("unexpected segment word %h last %b",
                                              m_tdata, m_tlast));
                end else begin
                    want = pending_segs.pop_front();
                    if (m_tdata[0] !== want.lit)
                        report_mismatch($sformatf("led_lit %b, want %b", m_tdata[0], want.lit));
                    if (m_tdata[3:1] !== want.units)
                        report_mismatch($sformatf("units %0d, want %0d",
                                                  m_tdata[3:1], want.units));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("tlast %b, want %b", m_tlast, want.last));
                    if (m_tdata[7:4] !== 4'b0)
                        report_mismatch($sformatf("pad bits %b not zero", m_tdata[7:4]));
                end
            end
        end
        n_pending = pending_segs.size();
    end

endmodule

// File: tb/sv/tb_morse_keyer.sv
// Testbench top for morse_keyer: clock, reset, character stimulus and output stalls.
// Checking is done by morse_seg_checker instantiated beside the DUT.
`timescale 1ns / 100ps

module tb_morse_keyer;

    localparam int RANDOM_CHARS = 390;
    // directed characters, sent from the top byte down
    localparam logic [8*25-1:0] DIRECTED_CHARS = {
        8'd0,   8'd255, 8'd8,   8'd9,   8'd13,  8'd14,  8'd31,  8'd32,
        8'd32,  8'd33,  "@",    "A",    "Z",    "[",    "/",    "0",
        "9",    ":",    "3",    "E",    "T",    "a",    " ",    8'd10,
        "Q"
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    int         errors;
    int         n_pending;
    logic       quiet = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    morse_keyer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    morse_seg_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .errors    (errors),
        .n_pending (n_pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // called and returns just after a rising edge
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(negedge aclk);
        while (!s_tready)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    initial begin
        int n;
        @(posedge aclk);
        forever begin
            n = pick_gap();
            if (n != 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            n = $urandom_range(1, 8);
            repeat (n) @(posedge aclk);
        end
    end

    initial begin
        int         sent;
        int         r;
        logic [7:0] c;
        logic       prev_white;
        logic       white;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 24; i >= 0; i--)
            send_char(DIRECTED_CHARS[i*8 +: 8]);
        prev_white = 1'b1;   // directed list ends on a letter, but stay conservative

        sent = 0;
        while (sent < RANDOM_CHARS) begin
            quiet = (sent % 80) >= 62;
            r = $urandom_range(0, 99);
            if (r < 55)
                c = 8'($urandom_range(65, 90));
            else if (r < 70)
                c = 8'($urandom_range(48, 57));
            else if (r < 80)
                c = 8'd32;
            else if (r < 86)
                c = 8'($urandom_range(9, 13));
            else
                c = 8'($urandom_range(0, 255));
            white = (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
            send_char(c);
            if (!(white && prev_white))
                sent++;
            prev_white = white;
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;

        @(negedge aclk);
        while (n_pending != 0)
            @(negedge aclk);
        repeat (24) @(posedge aclk);
        @(negedge aclk);

        if (errors == 0 && n_pending == 0)
            $display("morse_keyer regression: pass");
        else
            $display("morse_keyer regression: fail");
        $finish;
    end

    initial begin
        #5000000;
        $display("morse_keyer regression: fail");
        $finish;
    end

endmodule
